>>> rtl/ipd_pkg.sv
// shared types and constants of the image pair diff engine
`timescale 1ns / 1ps

package ipd_pkg;

	// field widths
	localparam int unsigned PIX_W      = 32;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_HEIGHT  = 3'd4;

	// item opcodes and result kinds
	localparam logic OP_COMPARE   = 1'b0;
	localparam logic OP_FINISH    = 1'b1;
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// metric modes
	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_DELTA = 1'b1;

	// pixel constants
	localparam logic [PIX_W-1:0] RED_OPAQUE  = 32'hff00_00ff;
	localparam logic [PIX_W-1:0] PERCENT_ONE = 32'h0064_0000;

	// metric arithmetic widths; 100 * 65536 = 25 << 18
	localparam int unsigned PROD_W      = 2 * DIM_W;
	localparam int unsigned EXTRA_W     = PROD_W + 1;
	localparam int unsigned NUM_W       = 36;
	localparam int unsigned DEN_W       = PROD_W + 8;
	localparam int unsigned N25_W       = NUM_W + 5;
	localparam int unsigned SCALE_SHIFT = 18;
	localparam int unsigned LOW_W       = PIX_W - SCALE_SHIFT;
	localparam int unsigned REM_W       = DEN_W + 1;
	localparam int unsigned DIV_STEPS   = PIX_W;
	localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NUM,
		ST_SCALE,
		ST_INIT,
		ST_DIV,
		ST_DONE
	} ipd_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_pixel;
		logic calc_mul;
		logic calc_num;
		logic calc_scale;
		logic div_init;
		logic div_step;
		logic load_summary;
		logic clear_acc;
	} ipd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic area_zero;
		logic quot_over;
	} ipd_stat_t;

endpackage

>>> rtl/ipd_if.sv
// input and output item channel interfaces
`timescale 1ns / 1ps

interface ipd_in_if import ipd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [PIX_W-1:0] reference_pixel;
	logic [PIX_W-1:0] test_pixel;

	modport source (output valid, output opcode, output reference_pixel, output test_pixel,
		input ready);
	modport sink (input valid, input opcode, input reference_pixel, input test_pixel,
		output ready);
endinterface

interface ipd_out_if import ipd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic             pixel_differs;
	logic [PIX_W-1:0] diff_pixel;
	logic [PIX_W-1:0] percent_fixed;
	logic             images_same;

	modport source (output valid, output result_kind, output pixel_differs,
		output diff_pixel, output percent_fixed, output images_same, input ready);
	modport sink (input valid, input result_kind, input pixel_differs,
		input diff_pixel, input percent_fixed, input images_same, output ready);
endinterface

>>> rtl/ipd_ctrl.sv
// controller state machine of the image pair diff engine
`timescale 1ns / 1ps

module ipd_ctrl import ipd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_opcode,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	output ipd_cmd_t  cmd,
	input  ipd_stat_t stat
);

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	ipd_state_t       state_q;
	ipd_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	// output register is free when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_opcode == OP_FINISH) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_NUM;
			ST_NUM:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_INIT;
			ST_INIT: begin
				state_d = (stat.area_zero || stat.quot_over) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load_pixel = accept && in_opcode == OP_COMPARE;
			ST_MUL:   cmd.calc_mul   = 1'b1;
			ST_NUM:   cmd.calc_num   = 1'b1;
			ST_SCALE: cmd.calc_scale = 1'b1;
			ST_INIT:  cmd.div_init   = 1'b1;
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_DONE: begin
				cmd.load_summary = out_free;
				cmd.clear_acc    = out_free;
			end
			default: cmd = '0;
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_pixel || cmd.load_summary) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the division runs its full number of steps
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DIV_LAST) |=> state_q == ST_DONE)
		else $error("division did not end after its last step");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_pixel || cmd.load_summary) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");

	// summary is presented and the block returns to idle
	a_summary_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_summary |=> (out_valid_q && state_q == ST_IDLE))
		else $error("summary not presented after finish");

	// no item taken while a finish is in progress
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("item accepted during finish");

endmodule

>>> rtl/ipd_dpath.sv
// datapath of the image pair diff engine: pixel compare, accumulators, metric divider
`timescale 1ns / 1ps

module ipd_dpath import ipd_pkg::*; #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [PIX_W-1:0]      reference_pixel,
	input  logic [PIX_W-1:0]      test_pixel,
	input  ipd_cmd_t              cmd,
	output ipd_stat_t             stat,
	output logic                  result_kind,
	output logic                  pixel_differs,
	output logic [PIX_W-1:0]      diff_pixel,
	output logic [PIX_W-1:0]      percent_fixed,
	output logic                  images_same
);

	localparam logic [DIM_W+1:0] MAX_DIM_EXT = (DIM_W + 2)'(MAX_DIM);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return ({2'b00, d} > MAX_DIM_EXT) ? MAX_DIM_EXT[DIM_W-1:0] : d;
	endfunction

	// configuration registers
	logic             mode_q;
	logic [DIM_W-1:0] tw_q, th_q, rw_q, rh_q;

	// accumulators
	logic [PIX_W-1:0] sum_q;
	logic             any_q;

	// metric pipeline
	logic [PROD_W-1:0] ext1_q, ext2_q, area_q;
	logic              same_snap_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              area_zero_q;
	logic [N25_W-1:0]  num25_q;
	logic [REM_W-1:0]  rem_q;
	logic [PIX_W-1:0]  qbits_q;

	// output register
	logic             kind_q, differs_q, same_q;
	logic [PIX_W-1:0] pix_q, pct_q;

	// pixel compare
	logic             differs;
	logic [7:0]       d_r, d_g, d_b, d_rg, delta;
	logic [7:0]       alpha;
	logic [PIX_W-1:0] pix;
	logic [PIX_W-1:0] inc;
	logic [PIX_W:0]   sum_ext;

	// overlap geometry
	logic [DIM_W-1:0] tw, th, rw, rh, w, h, mw, mh;
	logic             sizes_match;

	// metric arithmetic
	logic [EXTRA_W-1:0] extra;
	logic [NUM_W-1:0]   extra_sc;
	logic [REM_W-1:0]   trial;
	logic               ge;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COUNT;
			tw_q   <= '0;
			th_q   <= '0;
			rw_q   <= '0;
			rh_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_METRIC_MODE: mode_q <= cfg_wdata[0];
				CFG_TEST_WIDTH:  tw_q   <= cfg_wdata[DIM_W-1:0];
				CFG_TEST_HEIGHT: th_q   <= cfg_wdata[DIM_W-1:0];
				CFG_REF_WIDTH:   rw_q   <= cfg_wdata[DIM_W-1:0];
				CFG_REF_HEIGHT:  rh_q   <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// per pair compare, largest channel delta and faded pixel
	always_comb begin
		differs = reference_pixel != test_pixel;
		d_r     = abs_diff(reference_pixel[7:0], test_pixel[7:0]);
		d_g     = abs_diff(reference_pixel[15:8], test_pixel[15:8]);
		d_b     = abs_diff(reference_pixel[23:16], test_pixel[23:16]);
		d_rg    = (d_r > d_g) ? d_r : d_g;
		delta   = (d_rg > d_b) ? d_rg : d_b;
		alpha   = reference_pixel[31:24] - {1'b0, reference_pixel[31:25]};
		pix     = differs ? RED_OPAQUE : {alpha, reference_pixel[23:0]};
		inc     = (mode_q == MODE_DELTA) ? {24'd0, delta} : 32'd1;
		sum_ext = {1'b0, sum_q} + {1'b0, inc};
	end

	// accumulators, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.clear_acc) begin
			sum_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.load_pixel && differs) begin
			sum_q <= sum_ext[PIX_W] ? '1 : sum_ext[PIX_W-1:0];
			any_q <= 1'b1;
		end
	end

	// overlap and bounding sizes
	always_comb begin
		tw          = clamp_dim(tw_q);
		th          = clamp_dim(th_q);
		rw          = clamp_dim(rw_q);
		rh          = clamp_dim(rh_q);
		w           = (tw < rw) ? tw : rw;
		h           = (th < rh) ? th : rh;
		mw          = (tw > rw) ? tw : rw;
		mh          = (th > rh) ? th : rh;
		sizes_match = (tw == rw) && (th == rh);
	end

	// non-overlap area and numerator scaling
	always_comb begin
		extra    = EXTRA_W'(ext1_q) + EXTRA_W'(ext2_q);
		extra_sc = (mode_q == MODE_DELTA) ? (NUM_W'(extra) << 8) - NUM_W'(extra)
			: NUM_W'(extra);
		trial    = {rem_q[REM_W-2:0], qbits_q[PIX_W-1]};
		ge       = trial >= REM_W'(den_q);
	end

	// metric pipeline and restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.calc_mul) begin
			ext1_q      <= PROD_W'(mw - w) * PROD_W'(h);
			ext2_q      <= PROD_W'(mh - h) * PROD_W'(mw);
			area_q      <= PROD_W'(rw) * PROD_W'(rh);
			same_snap_q <= sizes_match && !any_q;
		end
		if (cmd.calc_num) begin
			num_q       <= NUM_W'(sum_q) + extra_sc;
			den_q       <= (mode_q == MODE_DELTA) ? (DEN_W'(area_q) << 8) - DEN_W'(area_q)
				: DEN_W'(area_q);
			area_zero_q <= area_q == '0;
		end
		if (cmd.calc_scale) begin
			num25_q <= (N25_W'(num_q) << 4) + (N25_W'(num_q) << 3) + N25_W'(num_q);
		end
		if (cmd.div_init) begin
			rem_q   <= REM_W'(num25_q[N25_W-1:LOW_W]);
			qbits_q <= {num25_q[LOW_W-1:0], {SCALE_SHIFT{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q   <= ge ? trial - REM_W'(den_q) : trial;
			qbits_q <= {qbits_q[PIX_W-2:0], ge};
		end
	end

	// quotient would not fit 32 bits when the high dividend part reaches the divisor
	assign stat.area_zero = area_zero_q;
	assign stat.quot_over = DEN_W'(num25_q[N25_W-1:LOW_W]) >= den_q;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			kind_q    <= KIND_PIXEL;
			differs_q <= differs;
			pix_q     <= pix;
			pct_q     <= '0;
			same_q    <= 1'b0;
		end else if (cmd.load_summary) begin
			kind_q    <= KIND_SUMMARY;
			differs_q <= 1'b0;
			pix_q     <= '0;
			same_q    <= same_snap_q;
			if (area_zero_q) begin
				pct_q <= PERCENT_ONE;
			end else if (stat.quot_over) begin
				pct_q <= '1;
			end else begin
				pct_q <= qbits_q;
			end
		end
	end

	assign result_kind   = kind_q;
	assign pixel_differs = differs_q;
	assign diff_pixel    = pix_q;
	assign percent_fixed = pct_q;
	assign images_same   = same_q;

	// partial remainder stays below the divisor through the division
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < REM_W'(den_q)))
		else $error("divider remainder out of range");

endmodule

>>> rtl/image_pair_diff_engine.sv
// top level of the image pair diff engine
// compare item: result in the output register in the cycle after acceptance; one item per cycle while out_ready is high
// finish item: summary computed through states MUL, NUM, SCALE, INIT, DIV and DONE;
//   DIV holds the 32 steps of the bit-serial restoring divider, skipped if area is empty or saturates
// no item is accepted until the summary is in the output register
// arst_n clears configuration, accumulators, controller state and valid; no clearing pass
`timescale 1ns / 1ps

module image_pair_diff_engine import ipd_pkg::*; #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ipd_in_if.sink                in_ch,
	ipd_out_if.source             out_ch
);

	ipd_cmd_t  cmd;
	ipd_stat_t stat;

	// sequencing of items and of the finish computation
	ipd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	// compare, accumulate, metric and result register
	ipd_dpath #(
		.MAX_DIM (MAX_DIM)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.reference_pixel (in_ch.reference_pixel),
		.test_pixel      (in_ch.test_pixel),
		.cmd             (cmd),
		.stat            (stat),
		.result_kind     (out_ch.result_kind),
		.pixel_differs   (out_ch.pixel_differs),
		.diff_pixel      (out_ch.diff_pixel),
		.percent_fixed   (out_ch.percent_fixed),
		.images_same     (out_ch.images_same)
	);

endmodule
